[hdl/qrs_pkg.sv]
// Shared types, widths and helpers of the quadratic root solver.
// Used by the square-root cell, the divider cell and the top level; no dependencies.
package qrs_pkg;

  // Field and datapath widths
  localparam int unsigned CoefW   = 32;
  localparam int unsigned EpsW    = 16;
  localparam int unsigned DiscW   = 66;  // exact b*b-4ac before saturation
  localparam int unsigned RadW    = 66;  // square-root radicand, two bits per cell
  localparam int unsigned RootW   = RadW / 2;
  localparam int unsigned RemW    = RootW + 2;
  localparam int unsigned NumW    = 35;  // root numerators, signed
  localparam int unsigned DenW    = 33;  // 2a or b, signed
  localparam int unsigned DivXW   = 50;  // |numerator| * 2^16
  localparam int unsigned QuoW    = 33;  // quotient bits worked out by the cell row
  localparam int unsigned DivYW   = DenW + QuoW - 1;

  typedef enum logic [2:0] {
    CASE_IDENTITY = 3'd0,
    CASE_CONTRA   = 3'd1,
    CASE_LINEAR   = 3'd2,
    CASE_TWO_REAL = 3'd3,
    CASE_REPEATED = 3'd4,
    CASE_COMPLEX  = 3'd5
  } case_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_quad;
    logic signed [CoefW-1:0] coef_lin;
    logic signed [CoefW-1:0] coef_const;
  } coef_t;

  typedef struct packed {
    logic [2:0]              case_code;
    logic [1:0]              root_count;
    logic                    disc_valid;
    logic signed [63:0]      discriminant;
    logic signed [CoefW-1:0] first_real;
    logic signed [CoefW-1:0] first_imag;
    logic signed [CoefW-1:0] second_real;
    logic signed [CoefW-1:0] second_imag;
    logic                    overflow;
  } result_t;

  // Sideband carried along the square-root row
  typedef struct packed {
    case_e            code;
    logic [63:0]      disc;
    logic             disc_ovf;
    logic [CoefW-1:0] a;
    logic [CoefW-1:0] b;
    logic [CoefW-1:0] c;
  } sqrt_side_t;

  // Sideband carried along the divider row
  typedef struct packed {
    case_e       code;
    logic [63:0] disc;
    logic        disc_ovf;
    logic        neg1;
    logic        neg2;
    logic        big1;
    logic        big2;
  } div_side_t;

  // Zero, or magnitude below epsilon
  function automatic logic near_zero(input logic [CoefW-1:0] x, input logic [EpsW-1:0] eps);
    logic [CoefW:0] xs;
    logic [CoefW:0] mag;
    xs  = {x[CoefW-1], x};
    mag = x[CoefW-1] ? (~xs + 1'b1) : xs;
    return (x == '0) || (mag < {{(CoefW+1-EpsW){1'b0}}, eps});
  endfunction

  // Apply sign to a quotient magnitude and saturate; returns {overflow, value}
  function automatic logic [CoefW:0] sat_root(input logic [QuoW-1:0] q, input logic big,
                                              input logic neg);
    logic [CoefW-1:0] v;
    logic             o;
    logic [QuoW-1:0]  qn;
    qn = ~q + 1'b1;
    o  = 1'b0;
    v  = '0;
    if (big) begin
      o = 1'b1;
      v = neg ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else if (!neg) begin
      if (q > {2'b00, {(CoefW-1){1'b1}}}) begin
        o = 1'b1;
        v = {1'b0, {(CoefW-1){1'b1}}};
      end else begin
        v = q[CoefW-1:0];
      end
    end else begin
      if (q > {2'b01, {(CoefW-1){1'b0}}}) begin
        o = 1'b1;
        v = {1'b1, {(CoefW-1){1'b0}}};
      end else begin
        v = qn[CoefW-1:0];
      end
    end
    return {o, v};
  endfunction

endpackage

[hdl/qrs_sqrt_cell.sv]
// One cell of the square-root row: settles one root bit from two radicand bits.
// Depends on qrs_pkg for widths and the sideband type.
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RadW-1:0]  rad_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [RootW-1:0] root_i,
  input  sqrt_side_t       side_i,
  output logic             valid_o,
  output logic [RadW-1:0]  rad_o,
  output logic [RemW-1:0]  rem_o,
  output logic [RootW-1:0] root_o,
  output sqrt_side_t       side_o
);

  logic [RemW+1:0]  raw;
  logic [RemW+1:0]  trial;
  logic             take;
  logic [RemW-1:0]  rem_d;
  logic [RootW-1:0] root_d;
  logic [RadW-1:0]  rad_d;
  logic             valid_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  sqrt_side_t       side_q;

  // Trial subtract of 4*root+1 from the shifted remainder
  assign raw   = {rem_i, rad_i[RadW-1 -: 2]};
  assign trial = {{(RemW-RootW){1'b0}}, root_i, 2'b01};
  assign take  = (raw >= trial);

  always_comb begin
    rem_d  = take ? RemW'(raw - trial) : raw[RemW-1:0];
    root_d = {root_i[RootW-2:0], take};
    rad_d  = {rad_i[RadW-3:0], 2'b00};
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

`ifndef SYNTH
  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((RemW+1)'(rem_q) <= (RemW+1)'({root_q, 1'b0})))
    else $error("square-root remainder exceeds twice the partial root");
`endif

endmodule

[hdl/qrs_div_cell.sv]
// One cell of the divider row: settles one quotient bit in each of two lanes
// that share a divisor. Depends on qrs_pkg for widths and the sideband type.
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DivYW-1:0] ys_i,
  input  logic [DivXW-1:0] r1_i,
  input  logic [DivXW-1:0] r2_i,
  input  logic [QuoW-1:0]  q1_i,
  input  logic [QuoW-1:0]  q2_i,
  input  div_side_t        side_i,
  output logic             valid_o,
  output logic [DivYW-1:0] ys_o,
  output logic [DivXW-1:0] r1_o,
  output logic [DivXW-1:0] r2_o,
  output logic [QuoW-1:0]  q1_o,
  output logic [QuoW-1:0]  q2_o,
  output div_side_t        side_o
);

  logic             take1;
  logic             take2;
  logic [DivXW-1:0] r1_d;
  logic [DivXW-1:0] r2_d;
  logic             valid_q;
  logic [DivYW-1:0] ys_q;
  logic [DivXW-1:0] r1_q;
  logic [DivXW-1:0] r2_q;
  logic [QuoW-1:0]  q1_q;
  logic [QuoW-1:0]  q2_q;
  div_side_t        side_q;

  // Restoring step against the shifted divisor
  assign take1 = (DivYW'(r1_i) >= ys_i);
  assign take2 = (DivYW'(r2_i) >= ys_i);

  always_comb begin
    r1_d = take1 ? (r1_i - ys_i[DivXW-1:0]) : r1_i;
    r2_d = take2 ? (r2_i - ys_i[DivXW-1:0]) : r2_i;
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Advance the payload; the divisor moves one place down per cell
  always_ff @(posedge clk_i) begin
    ys_q   <= {1'b0, ys_i[DivYW-1:1]};
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    q1_q   <= {q1_i[QuoW-2:0], take1};
    q2_q   <= {q2_i[QuoW-2:0], take2};
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign ys_o    = ys_q;
  assign r1_o    = r1_q;
  assign r2_o    = r2_q;
  assign q1_o    = q1_q;
  assign q2_o    = q2_q;
  assign side_o  = side_q;

`ifndef SYNTH
  // the last cell drops the divisor's low bit on the shift, so bound by it set
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !side_q.big1) |-> ((DivYW+1)'(r1_q) < {ys_q, 1'b1}))
    else $error("divider partial remainder not below the divisor");
`endif

endmodule

[hdl/quadratic_root_solver.sv]
// Quadratic root solver, pipelined from the accepting edge to the result strobe.
// Throughput one item per cycle; busy stays low and the receiver cannot stall results.
// The pipeline is the 33-cell square-root row and the 33-cell divider row, plus six
// registered stages around them. Reset clears every valid flag and sets epsilon to 1.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  coef_t           coef_i,
  output logic            result_valid_o,
  output result_t         result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [EpsW-1:0] cfg_data_i
);

  localparam int unsigned Latency = 3 + RootW + 2 + QuoW + 1;

  logic [EpsW-1:0] eps_q;
  logic            accept;

  // Epsilon register
  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      eps_q <= cfg_data_i;
    end
  end

  // ---------------- stage 1: products and near-zero tests ----------------
  logic                    p1_valid_q;
  logic [CoefW-1:0]        p1_a_q, p1_b_q, p1_c_q;
  logic signed [63:0]      p1_bb_q, p1_ac_q;
  logic                    p1_nza_q, p1_nzb_q, p1_nzc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_a_q   <= coef_i.coef_quad;
    p1_b_q   <= coef_i.coef_lin;
    p1_c_q   <= coef_i.coef_const;
    p1_bb_q  <= $signed(coef_i.coef_lin) * $signed(coef_i.coef_lin);
    p1_ac_q  <= $signed(coef_i.coef_quad) * $signed(coef_i.coef_const);
    p1_nza_q <= near_zero(coef_i.coef_quad, eps_q);
    p1_nzb_q <= near_zero(coef_i.coef_lin, eps_q);
    p1_nzc_q <= near_zero(coef_i.coef_const, eps_q);
  end

  // ---------------- stage 2: exact discriminant, degenerate cases ----------------
  logic             p2_valid_q;
  logic [DiscW-1:0] p2_d_d, p2_d_q;
  case_e            p2_code_d, p2_code_q;
  logic             p2_quad_q;
  logic [CoefW-1:0] p2_a_q, p2_b_q, p2_c_q;

  always_comb begin
    p2_d_d = {{2{p1_bb_q[63]}}, p1_bb_q} - {p1_ac_q, 2'b00};
    if (p1_nzb_q) begin
      p2_code_d = p1_nzc_q ? CASE_IDENTITY : CASE_CONTRA;
    end else begin
      p2_code_d = CASE_LINEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_d_q    <= p2_d_d;
    p2_code_q <= p2_code_d;
    p2_quad_q <= !p1_nza_q;
    p2_a_q    <= p1_a_q;
    p2_b_q    <= p1_b_q;
    p2_c_q    <= p1_c_q;
  end

  // ---------------- stage 3: saturate, classify, magnitude ----------------
  logic             p3_valid_q;
  logic [DiscW-1:0] epsd, epsd_neg, mag;
  logic             sat_hi, sat_lo, gt_pos, gt_neg;
  sqrt_side_t       p3_side_d, p3_side_q;
  logic [RadW-1:0]  p3_mag_d, p3_mag_q;

  always_comb begin
    epsd     = {{(DiscW-EpsW-16){1'b0}}, eps_q, 16'h0000};
    epsd_neg = ~epsd + 1'b1;
    sat_hi   = !p2_d_q[DiscW-1] && (p2_d_q[DiscW-2] || p2_d_q[DiscW-3]);
    sat_lo   = p2_d_q[DiscW-1] && !(p2_d_q[DiscW-2] && p2_d_q[DiscW-3]);
    gt_pos   = $signed(p2_d_q) > $signed(epsd);
    gt_neg   = $signed(p2_d_q) > $signed(epsd_neg);
    mag      = p2_d_q[DiscW-1] ? (~p2_d_q + 1'b1) : p2_d_q;

    p3_side_d.a = p2_a_q;
    p3_side_d.b = p2_b_q;
    p3_side_d.c = p2_c_q;
    if (p2_quad_q) begin
      if (gt_pos) begin
        p3_side_d.code = CASE_TWO_REAL;
      end else if (gt_neg) begin
        p3_side_d.code = CASE_REPEATED;
      end else begin
        p3_side_d.code = CASE_COMPLEX;
      end
      p3_side_d.disc_ovf = sat_hi || sat_lo;
      if (sat_hi) begin
        p3_side_d.disc = {1'b0, {63{1'b1}}};
      end else if (sat_lo) begin
        p3_side_d.disc = {1'b1, {63{1'b0}}};
      end else begin
        p3_side_d.disc = p2_d_q[63:0];
      end
      p3_mag_d = RadW'(mag);
    end else begin
      p3_side_d.code     = p2_code_q;
      p3_side_d.disc_ovf = 1'b0;
      p3_side_d.disc     = '0;
      p3_mag_d           = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else begin
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_side_q <= p3_side_d;
    p3_mag_q  <= p3_mag_d;
  end

  // ---------------- square-root row ----------------
  logic             sq_valid [RootW+1];
  logic [RadW-1:0]  sq_rad   [RootW+1];
  logic [RemW-1:0]  sq_rem   [RootW+1];
  logic [RootW-1:0] sq_root  [RootW+1];
  sqrt_side_t       sq_side  [RootW+1];

  assign sq_valid[0] = p3_valid_q;
  assign sq_rad[0]   = p3_mag_q;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = p3_side_q;

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[k]),
      .rad_i   (sq_rad[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_valid[k+1]),
      .rad_o   (sq_rad[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // ---------------- stage 4: numerators and denominator ----------------
  sqrt_side_t      sf;
  logic [NumW-1:0] sqs, nb, nc, n1_d, n2_d;
  logic [DenW-1:0] den_d;
  logic            p4_valid_q;
  logic [NumW-1:0] p4_n1_q, p4_n2_q;
  logic [DenW-1:0] p4_den_q;
  case_e           p4_code_q;
  logic [63:0]     p4_disc_q;
  logic            p4_dovf_q;

  always_comb begin
    sf  = sq_side[RootW];
    sqs = {{(NumW-RootW){1'b0}}, sq_root[RootW]};
    nb  = ~{{(NumW-CoefW){sf.b[CoefW-1]}}, sf.b} + 1'b1;
    nc  = ~{{(NumW-CoefW){sf.c[CoefW-1]}}, sf.c} + 1'b1;
    unique case (sf.code)
      CASE_LINEAR: begin
        n1_d  = nc;
        n2_d  = '0;
        den_d = {sf.b[CoefW-1], sf.b};
      end
      CASE_TWO_REAL: begin
        n1_d  = nb + sqs;
        n2_d  = nb - sqs;
        den_d = {sf.a, 1'b0};
      end
      CASE_REPEATED: begin
        n1_d  = nb;
        n2_d  = '0;
        den_d = {sf.a, 1'b0};
      end
      CASE_COMPLEX: begin
        n1_d  = nb;
        n2_d  = sqs;
        den_d = {sf.a, 1'b0};
      end
      default: begin
        n1_d  = '0;
        n2_d  = '0;
        den_d = DenW'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else begin
      p4_valid_q <= sq_valid[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    p4_n1_q   <= n1_d;
    p4_n2_q   <= n2_d;
    p4_den_q  <= den_d;
    p4_code_q <= sf.code;
    p4_disc_q <= sf.disc;
    p4_dovf_q <= sf.disc_ovf;
  end

  // ---------------- stage 5: magnitudes, signs, range check ----------------
  logic [NumW-1:0]  abs1, abs2;
  logic [DenW-1:0]  absd;
  logic [DivXW-1:0] x1_d, x2_d;
  div_side_t        p5_side_d, p5_side_q;
  logic             p5_valid_q;
  logic [DivXW-1:0] p5_x1_q, p5_x2_q;
  logic [DenW-1:0]  p5_y_q;

  always_comb begin
    abs1 = p4_n1_q[NumW-1] ? (~p4_n1_q + 1'b1) : p4_n1_q;
    abs2 = p4_n2_q[NumW-1] ? (~p4_n2_q + 1'b1) : p4_n2_q;
    absd = p4_den_q[DenW-1] ? (~p4_den_q + 1'b1) : p4_den_q;
    x1_d = {abs1[DivXW-17:0], 16'h0000};
    x2_d = {abs2[DivXW-17:0], 16'h0000};
    p5_side_d.code     = p4_code_q;
    p5_side_d.disc     = p4_disc_q;
    p5_side_d.disc_ovf = p4_dovf_q;
    p5_side_d.neg1     = p4_n1_q[NumW-1] ^ p4_den_q[DenW-1];
    p5_side_d.neg2     = p4_n2_q[NumW-1] ^ p4_den_q[DenW-1];
    // quotient of 2^QuoW or more saturates whatever its sign
    p5_side_d.big1     = DenW'(x1_d[DivXW-1:QuoW]) >= absd;
    p5_side_d.big2     = DenW'(x2_d[DivXW-1:QuoW]) >= absd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_valid_q <= 1'b0;
    end else begin
      p5_valid_q <= p4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p5_x1_q   <= x1_d;
    p5_x2_q   <= x2_d;
    p5_y_q    <= absd;
    p5_side_q <= p5_side_d;
  end

  // ---------------- divider row ----------------
  logic             dv_valid [QuoW+1];
  logic [DivYW-1:0] dv_ys    [QuoW+1];
  logic [DivXW-1:0] dv_r1    [QuoW+1];
  logic [DivXW-1:0] dv_r2    [QuoW+1];
  logic [QuoW-1:0]  dv_q1    [QuoW+1];
  logic [QuoW-1:0]  dv_q2    [QuoW+1];
  div_side_t        dv_side  [QuoW+1];

  assign dv_valid[0] = p5_valid_q;
  assign dv_ys[0]    = {p5_y_q, {(QuoW-1){1'b0}}};
  assign dv_r1[0]    = p5_x1_q;
  assign dv_r2[0]    = p5_x2_q;
  assign dv_q1[0]    = '0;
  assign dv_q2[0]    = '0;
  assign dv_side[0]  = p5_side_q;

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    qrs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[k]),
      .ys_i    (dv_ys[k]),
      .r1_i    (dv_r1[k]),
      .r2_i    (dv_r2[k]),
      .q1_i    (dv_q1[k]),
      .q2_i    (dv_q2[k]),
      .side_i  (dv_side[k]),
      .valid_o (dv_valid[k+1]),
      .ys_o    (dv_ys[k+1]),
      .r1_o    (dv_r1[k+1]),
      .r2_o    (dv_r2[k+1]),
      .q1_o    (dv_q1[k+1]),
      .q2_o    (dv_q2[k+1]),
      .side_o  (dv_side[k+1])
    );
  end

  // ---------------- output stage: sign, saturate, select fields ----------------
  div_side_t      df;
  logic [CoefW:0] s1, s2, s2n;
  result_t        res_d, res_q;
  logic           res_valid_q;

  always_comb begin
    df  = dv_side[QuoW];
    s1  = sat_root(dv_q1[QuoW], df.big1, df.neg1);
    s2  = sat_root(dv_q2[QuoW], df.big2, df.neg2);
    s2n = sat_root(dv_q2[QuoW], df.big2, !df.neg2);

    res_d              = '0;
    res_d.case_code    = df.code;
    res_d.discriminant = df.disc;
    unique case (df.code)
      CASE_LINEAR: begin
        res_d.root_count = 2'd1;
        res_d.first_real = s1[CoefW-1:0];
        res_d.overflow   = s1[CoefW];
      end
      CASE_TWO_REAL: begin
        res_d.root_count  = 2'd2;
        res_d.disc_valid  = 1'b1;
        res_d.first_real  = s1[CoefW-1:0];
        res_d.second_real = s2[CoefW-1:0];
        res_d.overflow    = df.disc_ovf || s1[CoefW] || s2[CoefW];
      end
      CASE_REPEATED: begin
        res_d.root_count = 2'd1;
        res_d.disc_valid = 1'b1;
        res_d.first_real = s1[CoefW-1:0];
        res_d.overflow   = df.disc_ovf || s1[CoefW];
      end
      CASE_COMPLEX: begin
        res_d.root_count  = 2'd2;
        res_d.disc_valid  = 1'b1;
        res_d.first_real  = s1[CoefW-1:0];
        res_d.second_real = s1[CoefW-1:0];
        res_d.first_imag  = s2[CoefW-1:0];
        res_d.second_imag = s2n[CoefW-1:0];
        res_d.overflow    = df.disc_ovf || s1[CoefW] || s2[CoefW] || s2n[CoefW];
      end
      default: begin
        res_d.root_count = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= dv_valid[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTH
  a_strobe_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, Latency))
    else $error("result strobe without an item accepted at the pipeline depth");

  a_disc_valid_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.disc_valid == (result_o.case_code == CASE_TWO_REAL ||
                                                result_o.case_code == CASE_REPEATED ||
                                                result_o.case_code == CASE_COMPLEX)))
    else $error("discriminant valid flag disagrees with case code");

  a_unused_disc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.disc_valid) |-> (result_o.discriminant == '0))
    else $error("discriminant field not cleared for a degenerate case");
`endif

endmodule

[tb/sv/quadratic_root_checker.sv]
// Checker for the quadratic root solver: watches the item, result and epsilon channels,
// predicts each result from the accepted coefficients and compares field by field.
// Depends on qrs_pkg for the coefficient and result types and the case codes.
module quadratic_root_checker
  import qrs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  coef_t           coef_i,
  input  logic            result_valid_o,
  input  result_t         result_o,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_o,
  input  logic [EpsW-1:0] cfg_data_i,
  output int              fail_count,
  output int              roots_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [EpsW-1:0] eps_q;
  result_t         expected_roots[$];
  int              mismatches;

  // Clamp to signed 32 bits, flagging saturation
  function automatic longint clamp32(input longint x, inout logic ov);
    if (x > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned num);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > num) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // floor(sqrt(4q + r)) for r in 0..3
  function automatic longint sqrt_quarter(input longint unsigned q, input longint unsigned r);
    longint unsigned s;
    longint          t;
    s = floor_sqrt(q);
    t = longint'(s * s + s) - longint'(q);
    if (4 * t + 1 - longint'(r) <= 0) return longint'(2 * s + 1);
    return longint'(2 * s);
  endfunction

  function automatic logic tiny(input longint x, input logic [EpsW-1:0] eps);
    longint mag;
    mag = (x < 0) ? -x : x;
    return (x == 0) || (mag < longint'(eps));
  endfunction

  function automatic result_t solve_quadratic(input coef_t k, input logic [EpsW-1:0] eps);
    longint          a, b, c, bb, m, br, epsd, den, disc, sq, im;
    longint          r1, i1, r2, i2;
    longint unsigned q, r;
    logic            ov;
    result_t         y;
    a  = longint'(k.coef_quad);
    b  = longint'(k.coef_lin);
    c  = longint'(k.coef_const);
    y  = '0;
    ov = 1'b0;
    disc = 0; r1 = 0; i1 = 0; r2 = 0; i2 = 0;
    if (tiny(a, eps)) begin
      if (tiny(b, eps)) begin
        y.case_code = tiny(c, eps) ? CASE_IDENTITY : CASE_CONTRA;
      end else begin
        y.case_code  = CASE_LINEAR;
        y.root_count = 2'd1;
        r1 = clamp32((-c * 65536) / b, ov);
      end
    end else begin
      bb   = b * b;
      m    = (bb >>> 2) - a * c;
      br   = bb & 3;
      epsd = longint'(eps) * 65536;
      den  = 2 * a;
      y.disc_valid = 1'b1;
      if (m >= (64'sd1 <<< 61)) begin
        disc = 64'h7fff_ffff_ffff_ffff;
        ov   = 1'b1;
      end else if (m < -(64'sd1 <<< 61)) begin
        disc = 64'h8000_0000_0000_0000;
        ov   = 1'b1;
      end else begin
        disc = 4 * m + br;
      end
      if (m >= 0) begin
        q = m; r = br;
      end else if (br == 0) begin
        q = -m; r = 0;
      end else begin
        q = -m - 1; r = 4 - br;
      end
      if (disc > epsd) begin
        sq = sqrt_quarter(q, r);
        y.case_code  = CASE_TWO_REAL;
        y.root_count = 2'd2;
        r1 = clamp32(((-b + sq) * 65536) / den, ov);
        r2 = clamp32(((-b - sq) * 65536) / den, ov);
      end else if (disc > -epsd) begin
        y.case_code  = CASE_REPEATED;
        y.root_count = 2'd1;
        r1 = clamp32((-b * 65536) / den, ov);
      end else begin
        sq = sqrt_quarter(q, r);
        im = (sq * 65536) / den;
        y.case_code  = CASE_COMPLEX;
        y.root_count = 2'd2;
        r1 = clamp32((-b * 65536) / den, ov);
        r2 = r1;
        i1 = clamp32(im, ov);
        i2 = clamp32(-im, ov);
      end
    end
    y.discriminant = disc;
    y.first_real   = r1[31:0];
    y.first_imag   = i1[31:0];
    y.second_real  = r2[31:0];
    y.second_imag  = i2[31:0];
    y.overflow     = ov;
    return y;
  endfunction

  // Track epsilon, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      eps_q      <= 16'd1;
      fail_count <= 0;
      roots_due  <= 0;
      mismatches = 0;
      expected_roots.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) eps_q <= cfg_data_i;
      if (start && !busy) begin
        expected_roots.insert(expected_roots.size(), solve_quadratic(coef_i, eps_q));
      end
      if (result_valid_o) begin
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result_o);
        end else begin
          want = expected_roots.pop_front();
          if (want.case_code !== result_o.case_code ||
              want.root_count !== result_o.root_count ||
              want.disc_valid !== result_o.disc_valid ||
              want.discriminant !== result_o.discriminant ||
              want.first_real !== result_o.first_real ||
              want.first_imag !== result_o.first_imag ||
              want.second_real !== result_o.second_real ||
              want.second_imag !== result_o.second_imag ||
              want.overflow !== result_o.overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch code %0d/%0d cnt %0d/%0d dv %0d/%0d ovf %0d/%0d",
                       want.case_code, result_o.case_code, want.root_count,
                       result_o.root_count, want.disc_valid, result_o.disc_valid,
                       want.overflow, result_o.overflow);
              $display("  disc %h/%h r1 %h/%h i1 %h/%h r2 %h/%h i2 %h/%h",
                       want.discriminant, result_o.discriminant, want.first_real,
                       result_o.first_real, want.first_imag, result_o.first_imag,
                       want.second_real, result_o.second_real, want.second_imag,
                       result_o.second_imag);
            end
          end
        end
        fail_count <= mismatches;
      end
      roots_due <= expected_roots.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the quadratic root solver testbench: clock, reset, coefficient and epsilon stimulus.
// Depends on qrs_pkg, quadratic_root_solver and quadratic_root_checker.
module testbench;
  import qrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 72;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  coef_t           coef_i = '0;
  logic            result_valid_o;
  result_t         result_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [EpsW-1:0] cfg_data_i = '0;
  int              fail_count;
  int              roots_due;
  logic [EpsW-1:0] eps_now = 16'd1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  quadratic_root_solver u_top (.*);

  quadratic_root_checker u_check (.*);

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, hold it until accepted, then idle a random while, possibly not at all
  task automatic send_coef(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    int g;
    start  <= 1'b1;
    coef_i <= '{coef_quad: a, coef_lin: b, coef_const: c};
    do @(posedge clk_i); while (busy);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Drain everything in flight, then write epsilon
  task automatic set_epsilon(input logic [EpsW-1:0] eps);
    start <= 1'b0;
    @(posedge clk_i);
    while (roots_due != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= eps;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    eps_now = eps;
  endtask

  function automatic logic [31:0] pick_coef();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return $urandom;
      3, 4:    return int'($urandom_range(0, 1048576)) - 524288;
      5:       return int'($urandom_range(0, 2 * eps_now + 2)) - int'(eps_now) - 1;
      6:       return 32'd0;
      7:       begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return int'($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  // Random items: mostly free picks, some near-repeated roots, some degenerate
  task automatic random_items(input int n);
    int          kind;
    longint      a, b, c;
    logic [31:0] ra;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        send_coef(pick_coef(), pick_coef(), pick_coef());
      end else if (kind < 8) begin
        a = int'($urandom_range(1, 1 << 20)) * (($urandom & 1) ? 1 : -1);
        b = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        c = (b * b) / (4 * a) + int'($urandom_range(0, 6)) - 3;
        send_coef(a[31:0], b[31:0], c[31:0]);
      end else begin
        ra = int'($urandom_range(0, 2 * eps_now)) - int'(eps_now);
        send_coef(ra, ($urandom & 1) ? pick_coef() : ra, pick_coef());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_epsilon(16'd1);
    // Degenerate forms
    send_coef(32'd0, 32'd0, 32'd0);
    send_coef(32'd0, 32'd0, 32'h0001_0000);
    send_coef(32'd0, 32'h0002_0000, 32'hfffc_0000);
    send_coef(32'd0, 32'h0000_0001, 32'h7fff_ffff);
    // Two real, repeated, complex with either sign of a
    send_coef(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
    send_coef(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_coef(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_coef(32'hffff_0000, 32'h0000_0000, 32'hffff_0000);
    // Extremes: saturated discriminant and roots
    send_coef(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_coef(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_coef(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coef(32'h0000_0002, 32'h7fff_ffff, 32'h0000_0000);
    send_coef(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
    send_coef(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff);
    send_coef(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    set_epsilon(16'hffff);
    // Coefficients just inside and outside the threshold; discriminant at the threshold
    send_coef(32'h0000_fffe, 32'h0000_ffff, 32'h0001_0000);
    send_coef(32'hffff_0001, 32'hffff_0001, 32'hffff_0001);
    send_coef(32'h0001_0000, 32'h0000_0000, 32'hffff_c001);
    send_coef(32'h0001_0000, 32'h0000_0000, 32'hffff_c000);
    send_coef(32'h0001_0000, 32'h0000_0000, 32'h0000_3fff);
    send_coef(32'h0001_0000, 32'h0000_0000, 32'h0000_4000);
    random_items(270);
    set_epsilon(16'd1);
    random_items(270);
    set_epsilon(16'($urandom_range(2, 65534)));
    random_items(270);
    set_epsilon(16'($urandom_range(1, 64)));
    random_items(270);
    start <= 1'b0;
    @(posedge clk_i);
    while (roots_due != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
    if (fail_count == 0 && roots_due == 0) begin
      $display("quadratic_root_solver verification clean");
    end else begin
      $display("quadratic_root_solver verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("quadratic_root_solver verification failed");
    $finish;
  end

endmodule
